/* src/voxel_line_ray_stepper_defines.svh */
// Assertion macros shared by the voxel line ray stepper RTL.
// Depends on a clk and an active-low rst_n in the module that expands them.
`ifndef VOXEL_LINE_RAY_STEPPER_DEFINES_SVH
`define VOXEL_LINE_RAY_STEPPER_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define VLRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define VLRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/vlrs_pkg.sv */
// Shared widths, codes and item types of the voxel line ray stepper.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.
package vlrs_pkg;

    localparam int COORD_BITS    = 16;
    localparam int DELTA_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS      = COORD_BITS + 3;
    localparam int IN_FIELD_BITS = 6 * COORD_BITS + 1;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = 1;
    localparam int OUT_USER_BITS = 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [DELTA_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    typedef struct packed {
        op_t          op;
        coord_t [2:0] start_pos;
        coord_t [2:0] end_pos;
        logic         solid;
    } item_t;

    typedef struct packed {
        coord_t [2:0] voxel;
        logic         done_res;
        logic         hit;
    } result_t;

endpackage

/* src/vlrs_in_stage.sv */
// Input register of the voxel line ray stepper: holds one accepted item.
// Depends on vlrs_pkg for the item type.
module vlrs_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  vlrs_pkg::item_t in_item,
    output logic            item_valid,
    output vlrs_pkg::item_t item,
    input  logic            take
);

    logic            valid_reg;
    logic            valid_next;
    vlrs_pkg::item_t item_reg;
    logic            accept;

    assign in_ready   = !valid_reg || take;
    assign accept     = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload: load on accept only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* src/vlrs_walker.sv */
// Line walk state and the single-pass load/step logic of the stepper.
// Depends on vlrs_pkg and the assertion macros in the defines header.
`include "voxel_line_ray_stepper_defines.svh"

module vlrs_walker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  vlrs_pkg::item_t   item,
    input  logic              out_free,
    output logic              take,
    output logic              res_valid,
    output vlrs_pkg::result_t res
);

    vlrs_pkg::coord_t [2:0] cur_pos_reg,     cur_pos_next;
    vlrs_pkg::coord_t       goal_major_reg,  goal_major_next;
    vlrs_pkg::delta_t [2:0] abs_delta_reg,   abs_delta_next;
    logic             [2:0] step_sign_reg,   step_sign_next;
    vlrs_pkg::axis_t        major_axis_reg,  major_axis_next;
    vlrs_pkg::err_t   [1:0] err_terms_reg,   err_terms_next;
    logic                   walk_active_reg, walk_active_next;
    logic                   probe_pending_reg, probe_pending_next;

    logic                   is_load;
    logic                   has_result;

    assign is_load    = (item.op == vlrs_pkg::OP_LOAD);
    assign has_result = !is_load && walk_active_reg;
    assign take       = item_valid && (!has_result || out_free);
    assign res_valid  = item_valid && has_result;

    always_comb
    begin
        logic signed [vlrs_pkg::DELTA_BITS-1:0] diff;
        vlrs_pkg::delta_t [2:0] ld_abs;
        logic             [2:0] ld_neg;
        vlrs_pkg::axis_t        ld_major;
        vlrs_pkg::delta_t       ld_dmaj, ld_da, ld_db;
        vlrs_pkg::coord_t       ld_goal;
        vlrs_pkg::axis_t        minor_a, minor_b;
        vlrs_pkg::delta_t       dmaj, da, db;
        logic                   move_a, move_b, move_i;
        vlrs_pkg::coord_t [2:0] step_pos;
        vlrs_pkg::err_t   [1:0] step_err;

        // load path: deltas, signs and the driving axis
        for (int i = 0; i < 3; i++)
        begin
            diff = {item.end_pos[i][vlrs_pkg::COORD_BITS-1], item.end_pos[i]}
                 - {item.start_pos[i][vlrs_pkg::COORD_BITS-1], item.start_pos[i]};
            ld_neg[i] = diff[vlrs_pkg::DELTA_BITS-1];
            ld_abs[i] = ld_neg[i] ? vlrs_pkg::delta_t'(-diff) : vlrs_pkg::delta_t'(diff);
        end

        // ties go to x first, then y
        if (ld_abs[0] >= ld_abs[1] && ld_abs[0] >= ld_abs[2])
        begin
            ld_major = vlrs_pkg::AXIS_X;
            ld_dmaj  = ld_abs[0];
            ld_da    = ld_abs[1];
            ld_db    = ld_abs[2];
            ld_goal  = item.end_pos[0];
        end
        else if (ld_abs[1] >= ld_abs[2])
        begin
            ld_major = vlrs_pkg::AXIS_Y;
            ld_dmaj  = ld_abs[1];
            ld_da    = ld_abs[0];
            ld_db    = ld_abs[2];
            ld_goal  = item.end_pos[1];
        end
        else
        begin
            ld_major = vlrs_pkg::AXIS_Z;
            ld_dmaj  = ld_abs[2];
            ld_da    = ld_abs[0];
            ld_db    = ld_abs[1];
            ld_goal  = item.end_pos[2];
        end

        // step path: minor axes of the stored driving axis
        case (major_axis_reg)
            vlrs_pkg::AXIS_X:
            begin
                minor_a = vlrs_pkg::AXIS_Y;
                minor_b = vlrs_pkg::AXIS_Z;
                dmaj    = abs_delta_reg[0];
                da      = abs_delta_reg[1];
                db      = abs_delta_reg[2];
            end
            vlrs_pkg::AXIS_Y:
            begin
                minor_a = vlrs_pkg::AXIS_X;
                minor_b = vlrs_pkg::AXIS_Z;
                dmaj    = abs_delta_reg[1];
                da      = abs_delta_reg[0];
                db      = abs_delta_reg[2];
            end
            default:
            begin
                minor_a = vlrs_pkg::AXIS_X;
                minor_b = vlrs_pkg::AXIS_Y;
                dmaj    = abs_delta_reg[2];
                da      = abs_delta_reg[0];
                db      = abs_delta_reg[1];
            end
        endcase

        move_a = !err_terms_reg[0][vlrs_pkg::ERR_BITS-1];
        move_b = !err_terms_reg[1][vlrs_pkg::ERR_BITS-1];

        for (int i = 0; i < 3; i++)
        begin
            move_i = (major_axis_reg == vlrs_pkg::axis_t'(i))
                  || (move_a && minor_a == vlrs_pkg::axis_t'(i))
                  || (move_b && minor_b == vlrs_pkg::axis_t'(i));
            if (!move_i)
            begin
                step_pos[i] = cur_pos_reg[i];
            end
            else if (step_sign_reg[i])
            begin
                step_pos[i] = cur_pos_reg[i] - vlrs_pkg::coord_t'(1);
            end
            else
            begin
                step_pos[i] = cur_pos_reg[i] + vlrs_pkg::coord_t'(1);
            end
        end

        step_err[0] = err_terms_reg[0] + vlrs_pkg::err_t'({da, 1'b0})
                    - (move_a ? vlrs_pkg::err_t'({dmaj, 1'b0}) : '0);
        step_err[1] = err_terms_reg[1] + vlrs_pkg::err_t'({db, 1'b0})
                    - (move_b ? vlrs_pkg::err_t'({dmaj, 1'b0}) : '0);

        // hold by default
        cur_pos_next       = cur_pos_reg;
        goal_major_next    = goal_major_reg;
        abs_delta_next     = abs_delta_reg;
        step_sign_next     = step_sign_reg;
        major_axis_next    = major_axis_reg;
        err_terms_next     = err_terms_reg;
        walk_active_next   = walk_active_reg;
        probe_pending_next = probe_pending_reg;
        res.voxel          = cur_pos_reg;
        res.done_res       = 1'b1;
        res.hit            = 1'b1;

        if (is_load)
        begin
            cur_pos_next       = item.start_pos;
            goal_major_next    = ld_goal;
            abs_delta_next     = ld_abs;
            step_sign_next     = ld_neg;
            major_axis_next    = ld_major;
            err_terms_next[0]  = vlrs_pkg::err_t'({ld_da, 1'b0}) - vlrs_pkg::err_t'(ld_dmaj);
            err_terms_next[1]  = vlrs_pkg::err_t'({ld_db, 1'b0}) - vlrs_pkg::err_t'(ld_dmaj);
            walk_active_next   = 1'b1;
            probe_pending_next = 1'b0;
        end
        else if (walk_active_reg)
        begin
            if (probe_pending_reg && item.solid)
            begin
                // report the hit on the voxel just probed
                walk_active_next   = 1'b0;
                probe_pending_next = 1'b0;
            end
            else if (cur_pos_reg[major_axis_reg] == goal_major_reg)
            begin
                // end reached: miss at the origin
                res.voxel          = '0;
                res.hit            = 1'b0;
                walk_active_next   = 1'b0;
                probe_pending_next = 1'b0;
            end
            else
            begin
                cur_pos_next       = step_pos;
                err_terms_next     = step_err;
                probe_pending_next = 1'b1;
                res.voxel          = step_pos;
                res.done_res       = 1'b0;
                res.hit            = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_active_reg   <= 1'b0;
            probe_pending_reg <= 1'b0;
        end
        else if (take)
        begin
            walk_active_reg   <= walk_active_next;
            probe_pending_reg <= probe_pending_next;
        end
    end

    // walk geometry: only read while a walk is active
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_pos_reg    <= cur_pos_next;
            goal_major_reg <= goal_major_next;
            abs_delta_reg  <= abs_delta_next;
            step_sign_reg  <= step_sign_next;
            major_axis_reg <= major_axis_next;
            err_terms_reg  <= err_terms_next;
        end
    end

    `VLRS_ASSERT_SAME(a_hit_is_final, res_valid && res.hit, res.done_res, "hit result not final")
    `VLRS_ASSERT_SAME(a_miss_at_origin, res_valid && res.done_res && !res.hit, res.voxel == '0, "miss result away from origin")
    `VLRS_ASSERT_SAME(a_idle_step_silent, item_valid && !is_load && !walk_active_reg, !res_valid, "result without an active walk")
    `VLRS_ASSERT_NEXT(a_probe_arms, take && res_valid && !res.done_res, probe_pending_reg, "probe did not arm the solid check")
    `VLRS_ASSERT_NEXT(a_final_ends_walk, take && res_valid && res.done_res, !walk_active_reg, "walk still active after final result")

endmodule

/* src/vlrs_out_stage.sv */
// Result register of the voxel line ray stepper, decoupling the receiver.
// Depends on vlrs_pkg for the result type.
module vlrs_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  vlrs_pkg::result_t res_in,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_ready,
    output vlrs_pkg::result_t res_out
);

    logic              valid_reg;
    logic              valid_next;
    vlrs_pkg::result_t res_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

/* src/voxel_line_ray_stepper.sv */
// Voxel line ray stepper: a 3D Bresenham walk between two integer voxels.
// Usage:
//   Slave channel (s_*): one transaction per command. s_tuser selects a load,
//   which stores the endpoints and restarts the walk, or a step, which moves
//   one voxel. The solid flag of a step reports the occupancy of the voxel
//   given by the previous result, looked up outside the block.
//   Master channel (m_*): one transaction per result. A load gives none; a
//   step gives a probe (m_tlast = 0), a hit on the last probe (m_tlast = 1,
//   m_tuser = 1) or a miss at the origin when the end is reached (m_tlast = 1,
//   m_tuser = 0). A step with no walk in progress gives nothing.
// Timing: an item is taken into the input register, processed in one pass
//   into the result register, which drives m_tvalid. One item per cycle is
//   accepted while the receiver keeps up; in a lookup loop the rate is set
//   by the round trip through the outside occupancy lookup, since each step
//   needs the answer to the last.
// Reset: asynchronous, active low; clears both stage valids and the walk, so
//   steps are ignored until the first load.
// Stall: with m_tready low the result register holds and the input register
//   fills, after which s_tready drops; loads and idle steps still drain.
module voxel_line_ray_stepper
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, solid; zero padded
    input  logic [vlrs_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // op
    input  logic [vlrs_pkg::IN_USER_BITS-1:0]    s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // voxel_x, voxel_y, voxel_z
    output logic [vlrs_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // hit
    output logic [vlrs_pkg::OUT_USER_BITS-1:0]   m_tuser,
    // done_res: final result of the walk
    output logic                                 m_tlast
);

    vlrs_pkg::item_t   in_item;
    vlrs_pkg::item_t   item;
    logic              item_valid;
    logic              take;
    logic              out_free;
    logic              res_valid;
    vlrs_pkg::result_t res;
    vlrs_pkg::result_t res_out;

    // unpack the slave transaction
    always_comb
    begin
        in_item.op = vlrs_pkg::op_t'(s_tuser[0]);
        for (int i = 0; i < 3; i++)
        begin
            in_item.start_pos[i] = s_tdata[i*vlrs_pkg::COORD_BITS +: vlrs_pkg::COORD_BITS];
            in_item.end_pos[i]   = s_tdata[(3+i)*vlrs_pkg::COORD_BITS +: vlrs_pkg::COORD_BITS];
        end
        in_item.solid = s_tdata[6*vlrs_pkg::COORD_BITS];
    end

    vlrs_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    vlrs_walker u_walker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    vlrs_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res_in    (res),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (res_out)
    );

    // pack the master transaction
    assign m_tdata = vlrs_pkg::OUT_DATA_BITS'({res_out.voxel[2], res_out.voxel[1],
                                               res_out.voxel[0]});
    assign m_tuser = res_out.hit;
    assign m_tlast = res_out.done_res;

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for the voxel line ray stepper: drives load and step commands
// over the input stream; checks every result against an in-bench walk or a fixed row.
// Depends on vlrs_pkg and the voxel_line_ray_stepper RTL only.
module testbench;

    import vlrs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 410;
    localparam int DRAIN_CYCLES = 8;

    // How a row of the directed table is checked
    typedef enum logic [1:0] {
        ROW_SILENT,     // no result may come
        ROW_FIXED,      // result typed into the table
        ROW_PREDICTED   // result worked out by the line walk below
    } row_check_t;

    typedef struct packed {
        item_t      stim;
        row_check_t check;
        result_t    want;
    } directed_row_t;

    logic                     clk;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic [IN_USER_BITS-1:0]  s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [OUT_USER_BITS-1:0] m_tuser;
    logic                     m_tlast;

    // Walk state mirrored from the block
    coord_t      trace_pos [3];
    coord_t      trace_goal;
    delta_t      trace_span [3];
    logic [2:0]  trace_neg;
    axis_t       trace_axis;
    err_t        trace_err [2];
    bit          walk_on;
    bit          probe_out;

    result_t       voxel_reports [$];
    directed_row_t stim_rows [$];
    int            send_idle_pct;
    int            stall_pct;
    int            effective_items;
    int            fail_count;
    int            cycle_count;
    string         axis_names [3] = '{"x", "y", "z"};

    voxel_line_ray_stepper dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Minor axes in the order the error terms use them
    function automatic int minor_of(input axis_t a, input bit second);
        if (second)
            return (a == AXIS_Z) ? 1 : 2;
        return (a == AXIS_X) ? 1 : 0;
    endfunction

    function automatic coord_t nudge(input coord_t v, input logic down);
        return down ? coord_t'(v - coord_t'(1)) : coord_t'(v + coord_t'(1));
    endfunction

    // Append an awaited result at the tail of the queue
    function automatic void queue_report(input result_t r);
        voxel_reports.insert(voxel_reports.size(), r);
    endfunction

    // Append a row to the directed table
    function automatic void add_row(input directed_row_t row);
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // Apply one accepted command to the mirrored walk; return 1 when it yields a result
    function automatic bit walk_line(input item_t it, output result_t r);
        int i;
        int k;
        int s;
        int e;
        int dm;
        int mi;
        r = '0;
        if (it.op == OP_LOAD)
        begin
            trace_neg = '0;
            for (i = 0; i < 3; i++)
            begin
                s = $signed(it.start_pos[i]);
                e = $signed(it.end_pos[i]);
                trace_span[i] = delta_t'((e >= s) ? e - s : s - e);
                trace_neg[i]  = (s > e);
                trace_pos[i]  = it.start_pos[i];
            end
            // ties go to x, then to y
            if (trace_span[0] >= trace_span[1] && trace_span[0] >= trace_span[2])
                trace_axis = AXIS_X;
            else if (trace_span[1] >= trace_span[2])
                trace_axis = AXIS_Y;
            else
                trace_axis = AXIS_Z;
            dm = int'(trace_axis);
            for (k = 0; k < 2; k++)
            begin
                mi = minor_of(trace_axis, k[0]);
                trace_err[k] = err_t'(2 * int'(trace_span[mi]) - int'(trace_span[dm]));
            end
            trace_goal = it.end_pos[dm];
            walk_on    = 1'b1;
            probe_out  = 1'b0;
            return 1'b0;
        end
        if (!walk_on)
            return 1'b0;
        if (probe_out && it.solid)
        begin
            for (i = 0; i < 3; i++)
                r.voxel[i] = trace_pos[i];
            r.done_res = 1'b1;
            r.hit      = 1'b1;
            walk_on    = 1'b0;
            probe_out  = 1'b0;
            return 1'b1;
        end
        dm = int'(trace_axis);
        if (trace_pos[dm] == trace_goal)
        begin
            // miss: reported at the origin
            r.done_res = 1'b1;
            walk_on    = 1'b0;
            probe_out  = 1'b0;
            return 1'b1;
        end
        trace_pos[dm] = nudge(trace_pos[dm], trace_neg[dm]);
        for (k = 0; k < 2; k++)
        begin
            mi = minor_of(trace_axis, k[0]);
            if (trace_err[k] >= 0)
            begin
                trace_pos[mi] = nudge(trace_pos[mi], trace_neg[mi]);
                trace_err[k]  = err_t'(int'(trace_err[k]) - 2 * int'(trace_span[dm]));
            end
            trace_err[k] = err_t'(int'(trace_err[k]) + 2 * int'(trace_span[mi]));
        end
        for (i = 0; i < 3; i++)
            r.voxel[i] = trace_pos[i];
        probe_out = 1'b1;
        return 1'b1;
    endfunction

    function automatic item_t mk_item(input op_t op, input int sx, input int sy, input int sz,
                                      input int ex, input int ey, input int ez,
                                      input logic solid);
        item_t it;
        it              = '0;
        it.op           = op;
        it.start_pos[0] = coord_t'(sx);
        it.start_pos[1] = coord_t'(sy);
        it.start_pos[2] = coord_t'(sz);
        it.end_pos[0]   = coord_t'(ex);
        it.end_pos[1]   = coord_t'(ey);
        it.end_pos[2]   = coord_t'(ez);
        it.solid        = solid;
        return it;
    endfunction

    function automatic result_t mk_res(input int x, input int y, input int z,
                                       input logic done, input logic hit);
        result_t r;
        r.voxel[0] = coord_t'(x);
        r.voxel[1] = coord_t'(y);
        r.voxel[2] = coord_t'(z);
        r.done_res = done;
        r.hit      = hit;
        return r;
    endfunction

    // Load with short spans from a random start, or with endpoints anywhere when wild
    function automatic item_t random_line(input bit wild);
        item_t it;
        int    span [3];
        int    i;
        int    lim;
        int    dm;
        int    s;
        int    e;
        it       = '0;
        it.op    = OP_LOAD;
        it.solid = 1'($urandom_range(1, 0));
        if (wild)
        begin
            for (i = 0; i < 3; i++)
            begin
                it.start_pos[i] = coord_t'($urandom);
                it.end_pos[i]   = coord_t'($urandom);
            end
            return it;
        end
        lim = ($urandom_range(29, 0) == 0) ? 300 : 24;
        dm  = $urandom_range(lim, 0);
        for (i = 0; i < 3; i++)
            span[i] = ($urandom_range(3, 0) == 0) ? dm : $urandom_range(dm, 0);
        span[$urandom_range(2, 0)] = dm;
        for (i = 0; i < 3; i++)
        begin
            case ($urandom_range(7, 0))
                0:       s = -32768;
                1:       s = 32767;
                default: s = $signed(coord_t'($urandom));
            endcase
            e = $urandom_range(1, 0) ? s + span[i] : s - span[i];
            // hold the line inside the coordinate range
            if (e > 32767)
                e = s - span[i];
            if (e < -32768)
                e = s + span[i];
            it.start_pos[i] = coord_t'(s);
            it.end_pos[i]   = coord_t'(e);
        end
        return it;
    endfunction

    // Step command; the endpoint fields carry random noise the block must ignore
    function automatic item_t random_step(input logic solid);
        item_t it;
        int    i;
        it       = '0;
        it.op    = OP_STEP;
        it.solid = solid;
        for (i = 0; i < 3; i++)
        begin
            it.start_pos[i] = coord_t'($urandom);
            it.end_pos[i]   = coord_t'($urandom);
        end
        return it;
    endfunction

    // Offer one command, hold it until the transaction completes, then record
    // what it should produce
    task automatic send_item(input item_t it, input row_check_t check, input result_t want);
        logic [IN_DATA_BITS-1:0] fields;
        result_t                 predicted;
        bit                      has_result;
        int                      i;
        fields = '0;
        for (i = 0; i < 3; i++)
        begin
            fields[COORD_BITS*i +: COORD_BITS]       = it.start_pos[i];
            fields[COORD_BITS*(i+3) +: COORD_BITS]   = it.end_pos[i];
        end
        fields[6*COORD_BITS] = it.solid;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= fields;
        s_tuser  <= IN_USER_BITS'(it.op);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (it.op == OP_LOAD || walk_on)
            effective_items++;
        has_result = walk_line(it, predicted);
        case (check)
            ROW_PREDICTED: if (has_result) queue_report(predicted);
            ROW_FIXED:     queue_report(want);
            default:       ;
        endcase
    endtask

    // Pause the sender until every awaited result has come back
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (voxel_reports.size() != 0)
            @(posedge clk);
    endtask

    // One walk to its end with rare solid answers, or a burst of noise:
    // wild loads, stray steps and walks cut short by a new load
    task automatic run_walk();
        int n;
        int k;
        if ($urandom_range(99, 0) < 85)
        begin
            send_item(random_line(1'b0), ROW_PREDICTED, '0);
            n = 0;
            while (walk_on && n < 400)
            begin
                send_item(random_step(probe_out ? ($urandom_range(15, 0) == 0)
                                                : 1'($urandom_range(1, 0))),
                          ROW_PREDICTED, '0);
                n++;
            end
        end
        else
        begin
            if ($urandom_range(1, 0) == 1)
                send_item(random_line(1'b1), ROW_PREDICTED, '0);
            n = $urandom_range(4, 0);
            for (k = 0; k < n; k++)
                send_item(random_step(1'($urandom_range(1, 0))), ROW_PREDICTED, '0);
        end
    endtask

    // Receiver: stall at the rate of the current phase
    always @(posedge clk)
        m_tready <= ($urandom_range(99, 0) >= stall_pct);

    // Compare each result transaction with the oldest awaited one
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        int      i;
        if (rst_n && m_tvalid && m_tready)
        begin
            for (i = 0; i < 3; i++)
                got.voxel[i] = m_tdata[COORD_BITS*i +: COORD_BITS];
            got.done_res = m_tlast;
            got.hit      = m_tuser[0];
            if (voxel_reports.size() == 0)
            begin
                $display("%0t: expected no result, got voxel %0d,%0d,%0d done_res %0b hit %0b",
                         $time, $signed(got.voxel[0]), $signed(got.voxel[1]),
                         $signed(got.voxel[2]), got.done_res, got.hit);
                fail_count++;
            end
            else
            begin
                want = voxel_reports.pop_front();
                for (i = 0; i < 3; i++)
                    if (got.voxel[i] !== want.voxel[i])
                    begin
                        $display("%0t: voxel_%s expected %0d got %0d", $time, axis_names[i],
                                 $signed(want.voxel[i]), $signed(got.voxel[i]));
                        fail_count++;
                    end
                if (got.done_res !== want.done_res)
                begin
                    $display("%0t: done_res expected %0b got %0b",
                             $time, want.done_res, got.done_res);
                    fail_count++;
                end
                if (got.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b got %0b", $time, want.hit, got.hit);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : main
        int phase;
        int goal_count;
        int r;
        send_idle_pct   = 0;
        stall_pct       = 0;
        effective_items = 0;
        fail_count      = 0;
        cycle_count     = 0;
        walk_on         = 1'b0;
        probe_out       = 1'b0;
        trace_neg       = '0;
        trace_axis      = AXIS_X;
        trace_goal      = '0;
        for (r = 0; r < 3; r++)
        begin
            trace_pos[r]  = '0;
            trace_span[r] = '0;
        end
        trace_err[0] = '0;
        trace_err[1] = '0;

        // Directed table: reset state, zero length, coordinate extremes, axis ties,
        // both step directions, ignored solid flags and a reload mid-walk
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b1),
                ROW_SILENT, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_SILENT, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_FIXED, mk_res(0, 0, 0, 1'b1, 1'b0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_SILENT, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_LOAD, -32768, -32768, -32768,
                -32765, -32767, -32768, 1'b1), ROW_SILENT, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b1),
                ROW_FIXED, mk_res(-32767, -32768, -32768, 1'b0, 1'b0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b1),
                ROW_FIXED, mk_res(-32767, -32768, -32768, 1'b1, 1'b1)});
        add_row(directed_row_t'{mk_item(OP_LOAD, 0, 0, 0, 5, 5, 5, 1'b0),
                ROW_SILENT, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_PREDICTED, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_PREDICTED, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_LOAD, 0, 0, 0, 1, 4, 4, 1'b0),
                ROW_SILENT, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_PREDICTED, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_LOAD, 10, -20, 30, 8, -21, 37, 1'b0),
                ROW_SILENT, result_t'('0)});
        for (r = 0; r < 3; r++)
            add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                    ROW_PREDICTED, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_LOAD, 32767, 32767, 32767,
                32765, 32766, 32767, 1'b0), ROW_SILENT, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_PREDICTED, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_PREDICTED, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_FIXED, mk_res(0, 0, 0, 1'b1, 1'b0)});
        add_row(directed_row_t'{mk_item(OP_LOAD, -32768, -32768, -32768,
                32767, 32767, 0, 1'b0), ROW_SILENT, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_PREDICTED, result_t'('0)});
        // reload while a probe is out: the pending answer must be dropped
        add_row(directed_row_t'{mk_item(OP_LOAD, 32767, -32768, 1,
                -32768, 32767, -1, 1'b0), ROW_SILENT, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b1),
                ROW_PREDICTED, result_t'('0)});
        add_row(directed_row_t'{mk_item(OP_STEP, 0, 0, 0, 0, 0, 0, 1'b0),
                ROW_PREDICTED, result_t'('0)});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < stim_rows.size(); r++)
            send_item(stim_rows[r].stim, stim_rows[r].check, stim_rows[r].want);
        drain_reports();

        // Random walks in four idling phases; drain between phases so the
        // sender sits idle with nothing in flight at least once
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 81; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            goal_count = effective_items + PHASE_ITEMS;
            while (effective_items < goal_count)
                run_walk();
            drain_reports();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
